/* rtl/assert_macros.svh */
// Assertion helpers for checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold on every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/jcsa_pkg.sv */
package jcsa_pkg;

  localparam int unsigned MagBits    = 16;
  localparam int unsigned MaxPixels  = 1048576;
  localparam int unsigned AccW       = 40;
  localparam int unsigned SimSumW    = 36;
  localparam int unsigned CountW     = 21;
  localparam int unsigned ProdW      = 2 * MagBits;
  localparam int unsigned NormW      = 24;
  localparam int unsigned RootW      = 24;
  // numerator is the shifted cross sum times 2^15
  localparam int unsigned QuotW      = AccW + 15;

  localparam logic [AccW-1:0]    AccMax    = {AccW{1'b1}};
  localparam logic [SimSumW-1:0] SimSumMax = {SimSumW{1'b1}};
  localparam longint unsigned CountFieldMax = (64'd1 << CountW) - 64'd1;
  localparam logic [CountW-1:0] CountLimit =
      CountW'((64'(MaxPixels) < CountFieldMax) ? 64'(MaxPixels) : CountFieldMax);
  localparam logic [16:0] OneQ15 = 17'd32768;

  typedef struct packed {
    logic [15:0] first_magnitude;
    logic [15:0] second_magnitude;
    logic        end_of_pixel;
    logic        end_of_image;
  } in_word_t;

  typedef struct packed {
    logic [15:0]       mean_similarity;
    logic [CountW-1:0] pixels_seen;
    logic              degenerate_seen;
    logic              last;
  } out_word_t;

  typedef enum logic [3:0] {
    StAccum,
    StMeanLoad,
    StMul2,
    StShift,
    StNormMul,
    StSqrt,
    StDiv,
    StAddSim,
    StMeanDiv,
    StOut
  } state_e;

  typedef struct packed {
    logic acc_en;
    logic close_start;
    logic shift_step;
    logic norm_mul;
    logic sqrt_start;
    logic sqrt_step;
    logic div_start;
    logic div_step;
    logic add_sim;
    logic mean_start;
    logic mean_step;
    logic out_load;
    logic clear_all;
  } cmd_t;

  typedef struct packed {
    logic shift_done;
    logic sqrt_done;
    logic div_done;
    logic mean_done;
    logic skip_pixel;
    logic eoi;
  } status_t;

endpackage

/* rtl/jcsa_datapath.sv */
module jcsa_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  jcsa_pkg::in_word_t  in_word_i,
  input  jcsa_pkg::cmd_t      cmd_i,
  output jcsa_pkg::status_t   status_o,
  output jcsa_pkg::out_word_t out_word_o
);

  localparam int unsigned AccW = jcsa_pkg::AccW;

  // per-item products registered before accumulation
  logic [jcsa_pkg::ProdW-1:0] pc_q, pa_q, pb_q;
  logic [AccW-1:0] c_q, a_q, b_q;
  logic [jcsa_pkg::SimSumW-1:0] sim_sum_q;
  logic [jcsa_pkg::CountW-1:0] count_q;
  logic degen_q, eoi_q, skip_q, pend_q;
  logic [AccW-1:0] sc_q, sa_q, sb_q;
  logic [47:0] ab_q;
  logic [jcsa_pkg::RootW-1:0] root_q;
  logic [49:0] sq_rem_q;
  logic [4:0] sq_cnt_q;
  logic [jcsa_pkg::QuotW-1:0] num_q, quot_q;
  logic [jcsa_pkg::RootW:0] drem_q;
  logic [5:0] div_cnt_q;
  logic [jcsa_pkg::SimSumW-1:0] mnum_q;
  logic [jcsa_pkg::CountW:0] mrem_q;
  logic [5:0] mcnt_q;
  jcsa_pkg::out_word_t out_q;

  logic [AccW:0] c_sum, a_sum, b_sum;
  logic a_big, b_big;
  logic [49:0] sq_trial;
  logic [jcsa_pkg::RootW+1:0] d_trial;
  logic [jcsa_pkg::CountW+1:0] m_trial;
  logic [jcsa_pkg::SimSumW:0] sim_add;
  logic [16:0] sim_val;

  logic [15:0] m1, m2;
  assign m1 = in_word_i.first_magnitude[jcsa_pkg::MagBits-1:0];
  assign m2 = in_word_i.second_magnitude[jcsa_pkg::MagBits-1:0];

  assign c_sum = {1'b0, c_q} + (AccW+1)'(pc_q);
  assign a_sum = {1'b0, a_q} + (AccW+1)'(pa_q);
  assign b_sum = {1'b0, b_q} + (AccW+1)'(pb_q);
  assign a_big = |sa_q[AccW-1:jcsa_pkg::NormW];
  assign b_big = |sb_q[AccW-1:jcsa_pkg::NormW];

  // restoring square root, one result bit per cycle
  assign sq_trial = {sq_rem_q[47:0], ab_q[47:46]} - {24'd0, root_q, 2'b01};
  // restoring divide by the root
  assign d_trial = {drem_q, num_q[jcsa_pkg::QuotW-1]} - {2'b00, root_q};
  assign m_trial = {mrem_q, mnum_q[jcsa_pkg::SimSumW-1]} - {2'b00, count_q};

  assign sim_val = (root_q == '0) ? 17'd0 :
                   ((|quot_q[jcsa_pkg::QuotW-1:17]) || quot_q[16:0] > jcsa_pkg::OneQ15) ?
                   jcsa_pkg::OneQ15 : quot_q[16:0];
  assign sim_add = {1'b0, sim_sum_q} + (jcsa_pkg::SimSumW+1)'(sim_val);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q    <= 1'b0;
      c_q       <= '0;
      a_q       <= '0;
      b_q       <= '0;
      sim_sum_q <= '0;
      count_q   <= '0;
      degen_q   <= 1'b0;
      eoi_q     <= 1'b0;
      skip_q    <= 1'b0;
    end else begin
      if (cmd_i.acc_en) begin
        pc_q   <= m1 * m2;
        pa_q   <= m1 * m1;
        pb_q   <= m2 * m2;
        pend_q <= in_word_i.end_of_pixel | in_word_i.end_of_image;
        eoi_q  <= in_word_i.end_of_image;
      end
      if (cmd_i.close_start) begin
        // fold last product and freeze the pixel sums
        sc_q <= c_sum[AccW] ? jcsa_pkg::AccMax : c_sum[AccW-1:0];
        sa_q <= a_sum[AccW] ? jcsa_pkg::AccMax : a_sum[AccW-1:0];
        sb_q <= b_sum[AccW] ? jcsa_pkg::AccMax : b_sum[AccW-1:0];
        skip_q <= (count_q >= jcsa_pkg::CountLimit);
        if (pend_q) begin
          c_q <= '0;
          a_q <= '0;
          b_q <= '0;
        end else begin
          c_q <= c_sum[AccW] ? jcsa_pkg::AccMax : c_sum[AccW-1:0];
          a_q <= a_sum[AccW] ? jcsa_pkg::AccMax : a_sum[AccW-1:0];
          b_q <= b_sum[AccW] ? jcsa_pkg::AccMax : b_sum[AccW-1:0];
        end
      end
      if (cmd_i.shift_step) begin
        if (a_big) sa_q <= sa_q >> 2;
        if (b_big) sb_q <= sb_q >> 2;
        // cross sum drops one bit for each norm that drops two
        if (a_big && b_big) begin
          sc_q <= sc_q >> 2;
        end else if (a_big || b_big) begin
          sc_q <= sc_q >> 1;
        end
      end
      if (cmd_i.norm_mul) begin
        ab_q <= sa_q[23:0] * sb_q[23:0];
      end
      if (cmd_i.sqrt_start) begin
        sq_rem_q <= '0;
        root_q   <= '0;
        sq_cnt_q <= '0;
      end
      if (cmd_i.sqrt_step) begin
        ab_q     <= ab_q << 2;
        sq_cnt_q <= sq_cnt_q + 5'd1;
        if (!sq_trial[49]) begin
          sq_rem_q <= sq_trial;
          root_q   <= {root_q[22:0], 1'b1};
        end else begin
          sq_rem_q <= {sq_rem_q[47:0], ab_q[47:46]};
          root_q   <= {root_q[22:0], 1'b0};
        end
      end
      if (cmd_i.div_start) begin
        num_q     <= {sc_q, 15'd0};
        quot_q    <= '0;
        drem_q    <= '0;
        div_cnt_q <= '0;
      end
      if (cmd_i.div_step) begin
        num_q     <= num_q << 1;
        div_cnt_q <= div_cnt_q + 6'd1;
        if (!d_trial[jcsa_pkg::RootW+1]) begin
          drem_q <= d_trial[jcsa_pkg::RootW:0];
          quot_q <= {quot_q[jcsa_pkg::QuotW-2:0], 1'b1};
        end else begin
          drem_q <= {drem_q[jcsa_pkg::RootW-1:0], num_q[jcsa_pkg::QuotW-1]};
          quot_q <= {quot_q[jcsa_pkg::QuotW-2:0], 1'b0};
        end
      end
      if (cmd_i.add_sim && !skip_q) begin
        count_q <= count_q + (jcsa_pkg::CountW)'(1);
        if (sa_q == '0 || sb_q == '0) begin
          degen_q <= 1'b1;
        end else begin
          sim_sum_q <= sim_add[jcsa_pkg::SimSumW] ? jcsa_pkg::SimSumMax :
                       sim_add[jcsa_pkg::SimSumW-1:0];
        end
      end
      if (cmd_i.mean_start) begin
        mnum_q <= sim_sum_q;
        mrem_q <= '0;
        mcnt_q <= '0;
      end
      if (cmd_i.mean_step) begin
        mcnt_q <= mcnt_q + 6'd1;
        if (!m_trial[jcsa_pkg::CountW+1]) begin
          mrem_q <= m_trial[jcsa_pkg::CountW:0];
          mnum_q <= {mnum_q[jcsa_pkg::SimSumW-2:0], 1'b1};
        end else begin
          mrem_q <= {mrem_q[jcsa_pkg::CountW-1:0], mnum_q[jcsa_pkg::SimSumW-1]};
          mnum_q <= {mnum_q[jcsa_pkg::SimSumW-2:0], 1'b0};
        end
      end
      if (cmd_i.clear_all) begin
        sim_sum_q <= '0;
        count_q   <= '0;
        degen_q   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.last            <= 1'b1;
      out_q.pixels_seen     <= count_q;
      out_q.degenerate_seen <= degen_q | (count_q == '0);
      if (count_q == '0) begin
        out_q.mean_similarity <= '0;
      end else if (|mnum_q[jcsa_pkg::SimSumW-1:16]) begin
        out_q.mean_similarity <= 16'h8000;
      end else begin
        out_q.mean_similarity <= (mnum_q[15:0] > 16'h8000) ? 16'h8000 : mnum_q[15:0];
      end
    end
  end

  // step counters are only looked at while their loop runs
  assign out_word_o          = out_q;
  assign status_o.shift_done = !a_big && !b_big;
  assign status_o.sqrt_done  = (sq_cnt_q == 5'd23);
  assign status_o.div_done   = (div_cnt_q == 6'(jcsa_pkg::QuotW - 1));
  assign status_o.mean_done  = (mcnt_q == 6'(jcsa_pkg::SimSumW - 1));
  assign status_o.skip_pixel = pend_q;
  assign status_o.eoi        = eoi_q;

endmodule

/* rtl/jcsa_ctrl.sv */
module jcsa_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  jcsa_pkg::status_t status_i,
  output jcsa_pkg::cmd_t    cmd_o
);

  jcsa_pkg::state_e state_q, state_d;
  logic prod_v_q;
  logic out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= jcsa_pkg::StAccum;
      prod_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      prod_v_q    <= cmd_o.acc_en;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    unique case (state_q)
      jcsa_pkg::StAccum: begin
        // product word from last cycle gets folded here
        cmd_o.close_start = prod_v_q;
        if (prod_v_q && status_i.skip_pixel) begin
          state_d = jcsa_pkg::StShift;
        end else begin
          in_ready_o   = 1'b1;
          cmd_o.acc_en = in_valid_i;
        end
      end
      jcsa_pkg::StShift: begin
        cmd_o.shift_step = 1'b1;
        if (status_i.shift_done) state_d = jcsa_pkg::StNormMul;
      end
      jcsa_pkg::StNormMul: begin
        cmd_o.norm_mul   = 1'b1;
        cmd_o.sqrt_start = 1'b1;
        state_d = jcsa_pkg::StSqrt;
      end
      jcsa_pkg::StSqrt: begin
        cmd_o.sqrt_step = 1'b1;
        if (status_i.sqrt_done) state_d = jcsa_pkg::StMul2;
      end
      jcsa_pkg::StMul2: begin
        cmd_o.div_start = 1'b1;
        state_d = jcsa_pkg::StDiv;
      end
      jcsa_pkg::StDiv: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_done) state_d = jcsa_pkg::StAddSim;
      end
      jcsa_pkg::StAddSim: begin
        cmd_o.add_sim = 1'b1;
        if (status_i.eoi) begin
          state_d = jcsa_pkg::StMeanLoad;
        end else begin
          state_d = jcsa_pkg::StAccum;
        end
      end
      jcsa_pkg::StMeanLoad: begin
        // sum now includes the closing pixel
        cmd_o.mean_start = 1'b1;
        state_d = jcsa_pkg::StMeanDiv;
      end
      jcsa_pkg::StMeanDiv: begin
        cmd_o.mean_step = 1'b1;
        if (status_i.mean_done) state_d = jcsa_pkg::StOut;
      end
      jcsa_pkg::StOut: begin
        if (!out_valid_q) begin
          cmd_o.out_load  = 1'b1;
          cmd_o.clear_all = 1'b1;
          out_valid_d     = 1'b1;
          state_d         = jcsa_pkg::StAccum;
        end
      end
      default: state_d = jcsa_pkg::StAccum;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

/* rtl/jcsa_core.sv */
module jcsa_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  jcsa_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output jcsa_pkg::out_word_t out_word_o
);

  // Product stage separates acceptance from folding, so a closing word
  // is folded in the cycle after it is taken.
  jcsa_pkg::cmd_t cmd;
  jcsa_pkg::status_t st;

  jcsa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .status_i   (st),
    .cmd_o      (cmd)
  );

  jcsa_datapath u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_word_i (in_word_i),
    .cmd_i     (cmd),
    .status_o  (st),
    .out_word_o(out_word_o)
  );

endmodule

/* rtl/jet_cosine_similarity_average.sv */
// channel | valid      | ready      | word
// input   | in_valid_i | in_ready_o | in_word_i (jcsa_pkg::in_word_t)
// output  | out_valid_o| out_ready_i| out_word_o (jcsa_pkg::out_word_t)
// One word per cycle inside a jet. After the word that closes a pixel the input
// stalls for the fold, 1 to 9 norm shift steps, multiply, 24-step root,
// divide load, 55-step divide and sum update.
// End of image adds mean load, 36-step mean divide and result load;
// the result load waits while the previous result is still untaken.
// Reset clears the running sums and the pixel count; the result register holds until taken.
module jet_cosine_similarity_average (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  jcsa_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output jcsa_pkg::out_word_t out_word_o
);

  jcsa_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_word_o (out_word_o)
  );

endmodule

/* rtl/jcsa_checker.sv */
`include "assert_macros.svh"

module jcsa_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input jcsa_pkg::out_word_t out_word_o
);

  `ASSERT_ALWAYS(a_last_set, clk_i, rst_ni, !out_valid_o || out_word_o.last, "last low")
  `ASSERT_ALWAYS(a_mean_max, clk_i, rst_ni,
    !out_valid_o || out_word_o.mean_similarity <= 16'h8000, "mean above one")
  `ASSERT_ALWAYS(a_empty_degen, clk_i, rst_ni,
    !out_valid_o || out_word_o.pixels_seen != '0 || out_word_o.degenerate_seen,
    "empty image not flagged")
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i,
    out_valid_o && $stable(out_word_o), "result dropped")
  `ASSERT_NEXT(a_in_hold, clk_i, rst_ni, in_valid_i && !in_ready_o, in_valid_i,
    "input word withdrawn")

endmodule

bind jet_cosine_similarity_average jcsa_checker u_chk (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_word_o (out_word_o)
);
